>>> rtl/sensor_reply_frame_check_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sensor reply frame checker
// Concurrent checks on clk, disabled while rst is high; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef SENSOR_REPLY_FRAME_CHECK_ASSERT_SVH
`define SENSOR_REPLY_FRAME_CHECK_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SRFC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sensor_reply_frame_check: same-cycle check failed");

// next-cycle implication
`define SRFC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sensor_reply_frame_check: next-cycle check failed");

`else

`define SRFC_ASSERT_IMP(lbl, ante, cons)
`define SRFC_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

>>> rtl/srfc_pkg.sv
// ----------------------------------------------------------------------------
// srfc_pkg
// Word types, frame positions and the CRC-16/Modbus byte update.
// ----------------------------------------------------------------------------
package srfc_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // position of a byte within the eight-byte reply
  localparam logic [2:0] POS_FIRST     = 3'd0;
  localparam logic [2:0] POS_HUM_HI    = 3'd2;
  localparam logic [2:0] POS_CRC_LO    = 3'd6;
  localparam logic [2:0] POS_LAST      = 3'd7;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } byte_word_t;

  typedef struct packed {
    logic        [15:0] humidity_raw;
    logic signed [15:0] temperature_raw;
    logic               crc_ok;
  } result_word_t;

  // one byte of CRC-16/Modbus, LSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                             input logic [7:0]  b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> rtl/srfc_frame_core.sv
// ----------------------------------------------------------------------------
// srfc_frame_core
// Input register, frame position tracking, running CRC and payload capture.
// ----------------------------------------------------------------------------
module srfc_frame_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  byte_valid,
  output logic                  byte_stall,
  input  srfc_pkg::byte_word_t  byte_data,
  input  logic                  hold,
  output logic                  res_load,
  output srfc_pkg::result_word_t res_data
);
  import srfc_pkg::*;

  `include "sensor_reply_frame_check_assert.svh"

  logic        a_valid;
  logic        a_valid_next;
  byte_word_t  a_word;
  logic        accept;
  logic        fire;
  logic [2:0]  pos;

  logic [2:0]  byte_position;
  logic [15:0] running_crc;
  logic [15:0] running_crc_next;
  logic [31:0] payload_hold;
  logic [31:0] payload_hold_next;
  logic [7:0]  crc_low_hold;
  logic [7:0]  crc_low_hold_next;

  // the input register empties only when the result side can take a word
  assign fire       = a_valid && !hold;
  assign byte_stall = a_valid && hold;
  assign accept     = byte_valid && !byte_stall;

  assign a_valid_next = accept ? 1'b1 : (fire ? 1'b0 : a_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= a_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_word <= byte_data;
    end
  end

  // start flag overrides the counter
  assign pos = a_word.frame_start ? POS_FIRST : byte_position;

  always_comb begin
    running_crc_next  = running_crc;
    payload_hold_next = payload_hold;
    crc_low_hold_next = crc_low_hold;
    if (pos == POS_FIRST) begin
      running_crc_next = crc16_byte(CRC_INIT, a_word.rx_byte);
    end else if (pos < POS_CRC_LO) begin
      running_crc_next = crc16_byte(running_crc, a_word.rx_byte);
    end
    if (pos >= POS_HUM_HI && pos < POS_CRC_LO) begin
      payload_hold_next = {payload_hold[23:0], a_word.rx_byte};
    end
    if (pos == POS_CRC_LO) begin
      crc_low_hold_next = a_word.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= POS_FIRST;
      running_crc   <= CRC_INIT;
      payload_hold  <= '0;
      crc_low_hold  <= '0;
    end else if (fire) begin
      byte_position <= pos + 3'd1;
      running_crc   <= running_crc_next;
      payload_hold  <= payload_hold_next;
      crc_low_hold  <= crc_low_hold_next;
    end
  end

  assign res_load                 = fire && (pos == POS_LAST);
  assign res_data.humidity_raw    = payload_hold[31:16];
  assign res_data.temperature_raw = payload_hold[15:0];
  assign res_data.crc_ok          = ({a_word.rx_byte, crc_low_hold} == running_crc);

  `SRFC_ASSERT_NXT(a_wrap_after_last, res_load, byte_position == POS_FIRST)
  `SRFC_ASSERT_NXT(a_start_restarts, fire && a_word.frame_start, byte_position == 3'd1)
  `SRFC_ASSERT_NXT(a_crc_restart, fire && (pos == POS_FIRST),
                   running_crc == crc16_byte(CRC_INIT, $past(a_word.rx_byte)))

endmodule

>>> rtl/srfc_out_reg.sv
// ----------------------------------------------------------------------------
// srfc_out_reg
// Result register holding one finished reply word until it is taken.
// ----------------------------------------------------------------------------
module srfc_out_reg (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  srfc_pkg::result_word_t load_data,
  output logic                   hold,
  output logic                   result_valid,
  input  logic                   result_stall,
  output srfc_pkg::result_word_t result_data
);
  import srfc_pkg::*;

  `include "sensor_reply_frame_check_assert.svh"

  logic valid;
  logic valid_next;

  assign hold       = valid && result_stall;
  assign valid_next = load ? 1'b1 : (hold ? 1'b1 : 1'b0);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_data <= load_data;
    end
  end

  assign result_valid = valid;

  `SRFC_ASSERT_IMP(a_no_overwrite, load, !(valid && result_stall))

endmodule

>>> rtl/sensor_reply_frame_check.sv
// ----------------------------------------------------------------------------
// sensor_reply_frame_check
// CRC-16/Modbus check and field extraction for an eight-byte sensor reply.
// ----------------------------------------------------------------------------
// Byte channel (byte_valid / byte_stall / byte_data): one reply byte per word,
// frame_start marks byte one and restarts the frame at any point. After the
// eighth byte the position wraps, so the next byte starts a new frame.
// Result channel (result_valid / result_stall / result_data): one word per
// frame, on its eighth byte: humidity (bytes 3-4), signed temperature
// (bytes 5-6), both big endian, and crc_ok from the CRC over bytes 1-6
// against bytes 7-8 (low first). A bad CRC still delivers the fields.
// Path: a byte taken from the channel lands in the input register, and on
// the eighth byte the result register loads the word computed from it.
// Throughput: one byte per cycle while byte_stall is low; the CRC update
// is combinational XOR logic between the input register and frame state.
// When the result register is full and stalled, byte_stall rises while a
// byte waits in the input register; a stalled result holds its word.
// Reset (synchronous, rst high): both registers empty, position 0, CRC
// 0xFFFF, held bytes cleared.
// ----------------------------------------------------------------------------
module sensor_reply_frame_check (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   byte_valid,
  output logic                   byte_stall,
  input  srfc_pkg::byte_word_t   byte_data,
  output logic                   result_valid,
  input  logic                   result_stall,
  output srfc_pkg::result_word_t result_data
);
  import srfc_pkg::*;

  logic         hold;
  logic         res_load;
  result_word_t res_data;

  srfc_frame_core u_core (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_data  (byte_data),
    .hold       (hold),
    .res_load   (res_load),
    .res_data   (res_data)
  );

  srfc_out_reg u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (res_load),
    .load_data    (res_data),
    .hold         (hold),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

endmodule
